FILE: rtl/nsv_pkg.sv
`timescale 1ns / 1ps

package nsv_pkg;

	localparam logic [7:0] MAX_LENGTH_RESET = 8'd82;
	localparam logic [7:0] MIN_LINE_BYTES   = 8'd6;
	localparam logic [7:0] COUNT_SAT        = 8'hFF;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_X_LO   = 8'h78;
	localparam logic [7:0] CH_X_UP   = 8'h58;

	localparam logic [23:0] ID_RMC = 24'h524D43;
	localparam logic [23:0] ID_GGA = 24'h474741;
	localparam logic [23:0] ID_GLL = 24'h474C4C;
	localparam logic [23:0] ID_VTG = 24'h565447;

	typedef enum logic [2:0] {
		STATUS_OK,
		STATUS_UNKNOWN_TYPE,
		STATUS_TOO_LONG,
		STATUS_CSUM_MALFORMED,
		STATUS_CSUM_MISMATCH
	} status_t;

	typedef enum logic [2:0] {
		TYPE_UNKNOWN,
		TYPE_RMC,
		TYPE_GGA,
		TYPE_GLL,
		TYPE_VTG
	} sentence_t;

	typedef enum logic [1:0] {
		DIG_NONE,
		DIG_ONE,
		DIG_TWO,
		DIG_BAD
	} digits_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_line;
	} word_t;

	typedef struct packed {
		status_t    status;
		sentence_t  sentence_type;
		logic [7:0] talker_first;
		logic [7:0] talker_second;
		logic [7:0] computed_checksum;
		logic       checksum_present;
	} verdict_t;

	// bit 4 set: not a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] d;
		d = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			d = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			d = {1'b0, c[3:0] + 4'd9};
		end
		return d;
	endfunction

	function automatic sentence_t type_of(input logic [23:0] id);
		sentence_t t;
		unique case (id)
			ID_RMC:  t = TYPE_RMC;
			ID_GGA:  t = TYPE_GGA;
			ID_GLL:  t = TYPE_GLL;
			ID_VTG:  t = TYPE_VTG;
			default: t = TYPE_UNKNOWN;
		endcase
		return t;
	endfunction

endpackage

FILE: rtl/nsv_channels.sv
`timescale 1ns / 1ps

interface nsv_word_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_line;

	modport source (output valid, output char_byte, output end_of_line, input ready);
	modport sink   (input valid, input char_byte, input end_of_line, output ready);
endinterface

interface nsv_verdict_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [2:0] sentence_type;
	logic [7:0] talker_first;
	logic [7:0] talker_second;
	logic [7:0] computed_checksum;
	logic       checksum_present;

	modport source (output valid, output status, output sentence_type, output talker_first,
		output talker_second, output computed_checksum, output checksum_present, input ready);
	modport sink   (input valid, input status, input sentence_type, input talker_first,
		input talker_second, input computed_checksum, input checksum_present, output ready);
endinterface

interface nsv_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] max_length;

	modport source (output valid, output max_length, input ready);
	modport sink   (input valid, input max_length, output ready);
endinterface

FILE: rtl/nmea_sentence_validator.sv
`timescale 1ns / 1ps

// channel       dir  payload
// nmea_in       in   char_byte, end_of_line
// verdict_out   out  status, sentence_type, talker_first, talker_second,
//                    computed_checksum, checksum_present
// cfg           in   max_length
//
// One word per cycle unless a waiting verdict stalls; the last word passes stage 1, then its verdict is registered.
// Stage 1 registers the word; the line-state update and verdict logic sit between
// stage 1 and the verdict register.
// Reset clears the line state and sets max_length to 82.
// A waiting verdict stalls only a last word in stage 1; other words keep flowing.
module nmea_sentence_validator import nsv_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	nsv_word_if.sink        nmea_in,
	nsv_verdict_if.source   verdict_out,
	nsv_cfg_if.sink         cfg
);

	logic [7:0] max_len_q;
	logic       valid_s1;
	word_t      word_s1;
	logic       out_valid_q;
	verdict_t   verdict_q;
	verdict_t   verdict;
	logic       out_free, advance, take, load;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LENGTH_RESET;
		end else if (cfg.valid) begin
			max_len_q <= cfg.max_length;
		end
	end

	assign out_free      = !out_valid_q || verdict_out.ready;
	assign advance       = valid_s1 && (!word_s1.end_of_line || out_free);
	assign nmea_in.ready = !valid_s1 || advance;
	assign take          = nmea_in.valid && nmea_in.ready;
	assign load          = advance && word_s1.end_of_line;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			word_s1 <= '{char_byte: nmea_in.char_byte, end_of_line: nmea_in.end_of_line};
		end
	end

	nsv_line_check u_line_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.word       (word_s1),
		.max_length (max_len_q),
		.verdict    (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (verdict_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) verdict_q <= verdict;
	end

	assign verdict_out.valid             = out_valid_q;
	assign verdict_out.status            = verdict_q.status;
	assign verdict_out.sentence_type     = verdict_q.sentence_type;
	assign verdict_out.talker_first      = verdict_q.talker_first;
	assign verdict_out.talker_second     = verdict_q.talker_second;
	assign verdict_out.computed_checksum = verdict_q.computed_checksum;
	assign verdict_out.checksum_present  = verdict_q.checksum_present;

	a_verdict_from_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && word_s1.end_of_line))
		else $error("verdict without a last word");

	a_ok_has_type: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && verdict_q.status == STATUS_OK |-> verdict_q.sentence_type != TYPE_UNKNOWN)
		else $error("ok verdict for unknown sentence type");

	a_unknown_no_talker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && verdict_q.sentence_type == TYPE_UNKNOWN
		|-> verdict_q.talker_first == 8'd0 && verdict_q.talker_second == 8'd0)
		else $error("talker reported for unknown sentence type");

	a_csum_status_needs_star: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !verdict_q.checksum_present
		|-> verdict_q.status != STATUS_CSUM_MALFORMED && verdict_q.status != STATUS_CSUM_MISMATCH)
		else $error("checksum error without a star");

endmodule

FILE: rtl/nsv_line_check.sv
`timescale 1ns / 1ps

module nsv_line_check import nsv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  word_t      word,
	input  logic [7:0] max_length,
	output verdict_t   verdict
);

	logic [7:0]  count_q, count_n;
	logic [7:0]  xor_q, xor_n;
	logic        dollar_q, dollar_n;
	logic        star_q, star_n;
	logic [1:0]  after_q, after_n;
	logic [7:0]  sent_q, sent_n;
	digits_t     digits_q, digits_n;
	logic [23:0] id_q, id_n;
	logic [15:0] talker_q, talker_n;

	logic [7:0]  c;
	logic [4:0]  hex;
	sentence_t   stype;
	logic        csum_bad;

	assign c   = word.char_byte;
	assign hex = hex_digit(c);

	always_comb begin
		dollar_n = dollar_q;
		talker_n = talker_q;
		id_n     = id_q;
		star_n   = star_q;
		xor_n    = xor_q;
		after_n  = after_q;
		sent_n   = sent_q;
		digits_n = digits_q;

		if (count_q == 8'd0) begin
			dollar_n = (c == CH_DOLLAR);
		end else if (count_q <= 8'd2) begin
			talker_n = {talker_q[7:0], c};
		end else if (count_q <= 8'd5) begin
			id_n = {id_q[15:0], c};
		end

		if (star_q) begin
			if (after_q == 2'd0) begin
				if (!hex[4]) begin
					sent_n   = {4'd0, hex[3:0]};
					digits_n = DIG_ONE;
				end else begin
					digits_n = DIG_BAD;
				end
			end else if (after_q == 2'd1 && digits_q == DIG_ONE) begin
				if (!hex[4]) begin
					sent_n   = {sent_q[3:0], hex[3:0]};
					digits_n = DIG_TWO;
				end else if ((c == CH_X_LO || c == CH_X_UP) && sent_q == 8'd0) begin
					// "0x" prefix
					digits_n = DIG_BAD;
				end
			end
			if (after_q != 2'd3) after_n = after_q + 2'd1;
		end else if (c == CH_STAR) begin
			star_n = 1'b1;
		end else if (count_q != 8'd0) begin
			xor_n = xor_q ^ c;
		end

		count_n = (count_q == COUNT_SAT) ? count_q : count_q + 8'd1;
	end

	always_comb begin
		stype    = (dollar_n && count_n >= MIN_LINE_BYTES) ? type_of(id_n) : TYPE_UNKNOWN;
		csum_bad = star_n && (after_n < 2'd2 || digits_n == DIG_NONE || digits_n == DIG_BAD);

		if (stype == TYPE_UNKNOWN)          verdict.status = STATUS_UNKNOWN_TYPE;
		else if (count_n > max_length)      verdict.status = STATUS_TOO_LONG;
		else if (csum_bad)                  verdict.status = STATUS_CSUM_MALFORMED;
		else if (star_n && sent_n != xor_n) verdict.status = STATUS_CSUM_MISMATCH;
		else                                verdict.status = STATUS_OK;

		verdict.sentence_type     = stype;
		verdict.talker_first      = (stype == TYPE_UNKNOWN) ? 8'd0 : talker_n[15:8];
		verdict.talker_second     = (stype == TYPE_UNKNOWN) ? 8'd0 : talker_n[7:0];
		verdict.computed_checksum = xor_n;
		verdict.checksum_present  = star_n;
	end

	// clear everything after the last word of a line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			xor_q    <= '0;
			dollar_q <= 1'b0;
			star_q   <= 1'b0;
			after_q  <= '0;
			sent_q   <= '0;
			digits_q <= DIG_NONE;
			id_q     <= '0;
			talker_q <= '0;
		end else if (step) begin
			if (word.end_of_line) begin
				count_q  <= '0;
				xor_q    <= '0;
				dollar_q <= 1'b0;
				star_q   <= 1'b0;
				after_q  <= '0;
				sent_q   <= '0;
				digits_q <= DIG_NONE;
				id_q     <= '0;
				talker_q <= '0;
			end else begin
				count_q  <= count_n;
				xor_q    <= xor_n;
				dollar_q <= dollar_n;
				star_q   <= star_n;
				after_q  <= after_n;
				sent_q   <= sent_n;
				digits_q <= digits_n;
				id_q     <= id_n;
				talker_q <= talker_n;
			end
		end
	end

	a_clear_after_line: assert property (@(posedge clk) disable iff (!arst_n)
		step && word.end_of_line |=> count_q == 8'd0 && !star_q && xor_q == 8'd0)
		else $error("line state not cleared after last word");

	a_digits_need_star: assert property (@(posedge clk) disable iff (!arst_n)
		!star_q |-> after_q == 2'd0 && digits_q == DIG_NONE)
		else $error("checksum digits collected before a star");

endmodule
